/* sv/histogram_entropy_estimator_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the histogram entropy estimator
// Shorthand for clocked assertions that are held off while reset is active.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_ENTROPY_ESTIMATOR_CORE_ASSERT_SVH
`define HISTOGRAM_ENTROPY_ESTIMATOR_CORE_ASSERT_SVH

// A property that must hold at every edge outside reset.
`define HEE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A cause in one cycle and its required effect in the next cycle.
`define HEE_ASSERT_NEXT(lbl, cause, effect, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cause) |=> (effect)) \
		else $error(msg);

`endif

/* sv/hee_pkg.sv */
// ----------------------------------------------------------------------------
// hee_pkg
// Types and fixed widths shared by the entropy estimator and its log2 unit.
// ----------------------------------------------------------------------------
package hee_pkg;

	localparam int SAMPLE_W = 8;   // width of a sample bin index
	localparam int CNT_W    = 16;  // bin counts, totals and run length
	localparam int E_W      = 4;   // integer part of log2 of a 16-bit value
	localparam int FRAC_W   = 16;  // fraction bits of log2
	localparam int LOG_W    = E_W + FRAC_W;
	localparam int Y_W      = 31;  // Q1.30 mantissa during squaring
	localparam int D_W      = CNT_W + LOG_W;  // c * log2(c) and N * log2(N)
	localparam int REM_W    = D_W + 1;        // divider remainder
	localparam int ENT_W    = 17;             // Q1.16 result
	localparam int DIV_CNT_W = 5;             // counts the quotient bits

	localparam logic [CNT_W-1:0] SPR_RESET = 16'd256;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INC,
		ST_EVAL,
		ST_WAITN,
		ST_RD,
		ST_CHK,
		ST_WAITC,
		ST_ACC,
		ST_CMP,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] x;
	} log_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [LOG_W-1:0] result;
	} log_rsp_t;

endpackage

/* sv/hee_log2.sv */
// ----------------------------------------------------------------------------
// hee_log2
// Iterative fixed-point log2 of a 16-bit value, one squaring per cycle.
// ----------------------------------------------------------------------------
module hee_log2 (
	input  logic              clk,
	input  logic              arst_n,
	input  hee_pkg::log_req_t req,
	output hee_pkg::log_rsp_t rsp
);
	import hee_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [3:0]        step_q;
	logic [Y_W-1:0]    y_q;
	logic [FRAC_W-1:0] frac_q;
	logic [E_W-1:0]    e_q;

	logic [E_W-1:0]     msb;
	logic [Y_W-1:0]     y_init;
	logic [2*Y_W-1:0]   sq;
	logic [Y_W:0]       sq_top;

	// Position of the leading one; zero input never reaches this unit.
	always_comb begin
		msb = '0;
		for (int i = 0; i < CNT_W; i++) begin
			if (req.x[i]) begin
				msb = E_W'(i);
			end
		end
	end

	assign y_init = {{(Y_W-CNT_W){1'b0}}, req.x} << (5'(Y_W-1) - {1'b0, msb});
	assign sq     = (2*Y_W)'(y_q) * (2*Y_W)'(y_q);
	assign sq_top = sq[2*Y_W-1:Y_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 4'd1;
				if (step_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			y_q    <= y_init;
			e_q    <= msb;
			frac_q <= '0;
		end else if (busy_q) begin
			// A square at or above two halves back into [1,2) and yields a one.
			if (sq_top[Y_W]) begin
				y_q <= sq_top[Y_W:1];
			end else begin
				y_q <= sq_top[Y_W-1:0];
			end
			frac_q <= {frac_q[FRAC_W-2:0], sq_top[Y_W]};
		end
	end

	assign rsp.busy   = busy_q;
	assign rsp.done   = done_q;
	assign rsp.result = {e_q, frac_q};

endmodule

/* sv/histogram_entropy_estimator_core.sv */
// ----------------------------------------------------------------------------
// histogram_entropy_estimator_core
// Histogram of sample bins with a normalized Shannon entropy per run.
// ----------------------------------------------------------------------------
// Each input beat carries one sample bin index. Indexes below NUM_BINS are
// counted in a bin memory with separate read and write ports; others only
// advance the run. A sample inside the bins is read, then the incremented
// count is written back before the next beat is taken; one outside is taken
// in the idle state alone. After samples_per_run beats (zero counts as one)
// the block walks the bin memory one entry at a time, clearing it as it goes,
// and sums c*log2(c) with a shared iterative log2 unit. Bins holding 0 or 1
// add nothing and skip the log2 unit; any larger count takes the sixteen log2
// squarings and the accumulate. log2(N) is formed at the start of the walk
// and a 17-step restoring divider forms the result; a run whose sum reaches
// the divisor skips the divider, and a degenerate run also skips log2(N).
// The result is 1 - S/(N*log2 N) in unsigned Q1.16; degenerate is set and
// the entropy is zero when fewer than two samples fell in range. A finished
// result sits in an output register, so the next run starts while it waits.
// After reset the block clears every entry of the bin memory before it
// takes the first beat; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`include "histogram_entropy_estimator_core_assert.svh"

module histogram_entropy_estimator_core #(
	parameter int NUM_BINS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_wr_en,
	input  logic [hee_pkg::CNT_W-1:0]     cfg_wr_data,
	// sample channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [hee_pkg::SAMPLE_W-1:0]  sample_bin,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [hee_pkg::ENT_W-1:0]     entropy_q16,
	output logic                          degenerate,
	output logic [hee_pkg::CNT_W-1:0]     counted_samples
);
	import hee_pkg::*;

	localparam int BIN_W = $clog2(NUM_BINS);
	localparam int ACC_W = D_W + BIN_W;
	localparam logic [SAMPLE_W:0] BIN_LIMIT = (SAMPLE_W+1)'(NUM_BINS);
	localparam logic [BIN_W-1:0]  LAST_BIN  = BIN_W'(NUM_BINS - 1);

	// Bin memory with a registered read port.
	logic [CNT_W-1:0] bin_mem [NUM_BINS];
	logic             mem_re;
	logic             mem_we;
	logic [BIN_W-1:0] mem_raddr;
	logic [BIN_W-1:0] mem_waddr;
	logic [CNT_W-1:0] mem_wdata;
	logic [CNT_W-1:0] mem_rdata_q;

	state_t state_q, state_d;

	logic [CNT_W-1:0]     spr_q;
	logic [CNT_W-1:0]     samples_taken_q;
	logic [CNT_W-1:0]     in_range_q;
	logic                 run_end_q;
	logic [CNT_W-1:0]     n_q;
	logic [BIN_W-1:0]     idx_q;
	logic [BIN_W-1:0]     addr_q;
	logic [CNT_W-1:0]     c_q;
	logic [D_W-1:0]       d_q;
	logic [D_W-1:0]       prod_q;
	logic [ACC_W-1:0]     acc_q;
	logic [REM_W-1:0]     rem_q;
	logic [ENT_W-1:0]     quot_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	logic             out_valid_q;
	logic [ENT_W-1:0] entropy_q;
	logic             degen_q;
	logic [CNT_W-1:0] counted_q;

	log_req_t log_req;
	log_rsp_t log_rsp;

	logic             in_accept;
	logic             in_range;
	logic [CNT_W-1:0] limit;
	logic [CNT_W:0]   taken;
	logic             run_end;
	logic [CNT_W-1:0] n_new;
	logic             idx_last;
	logic             n_small;
	logic             out_load;
	logic [REM_W-1:0] rem_shift;
	logic             rem_ge;

	assign in_accept = in_valid && in_ready;
	assign in_range  = {1'b0, sample_bin} < BIN_LIMIT;
	assign limit     = (spr_q == '0) ? CNT_W'(1) : spr_q;
	assign taken     = {1'b0, samples_taken_q} + (CNT_W+1)'(1);
	assign run_end   = taken >= {1'b0, limit};
	assign n_new     = in_range_q + CNT_W'(in_range);
	assign idx_last  = idx_q == LAST_BIN;
	assign n_small   = n_q < CNT_W'(2);

	// The first quotient bit compares the remainder unshifted: it is set
	// only when S is zero, which gives exactly 1.0.
	assign rem_shift = (div_cnt_q == '0) ? rem_q : {rem_q[REM_W-2:0], 1'b0};
	assign rem_ge    = rem_shift >= {1'b0, d_q};

	// Read happens before write, so the walk reads a count and clears the
	// same entry in the same cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			bin_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= bin_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		mem_re      = 1'b0;
		mem_we      = 1'b0;
		mem_raddr   = idx_q;
		mem_waddr   = idx_q;
		mem_wdata   = '0;
		log_req     = '0;
		out_load    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (idx_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_range) begin
						mem_re    = 1'b1;
						mem_raddr = sample_bin[BIN_W-1:0];
						state_d   = ST_INC;
					end else if (run_end) begin
						state_d = ST_EVAL;
					end
				end
			end
			ST_INC: begin
				// The next beat is read no earlier than the cycle after this
				// write, so the same bin never needs forwarding.
				mem_we    = 1'b1;
				mem_waddr = addr_q;
				mem_wdata = mem_rdata_q + CNT_W'(1);
				state_d   = run_end_q ? ST_EVAL : ST_IDLE;
			end
			ST_EVAL: begin
				// A degenerate run still walks the bins to clear them.
				if (n_small) begin
					state_d = ST_RD;
				end else begin
					log_req.start = 1'b1;
					log_req.x     = n_q;
					state_d       = ST_WAITN;
				end
			end
			ST_WAITN: begin
				if (log_rsp.done) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				mem_re  = 1'b1;
				mem_we  = 1'b1;
				state_d = ST_CHK;
			end
			ST_CHK: begin
				// Counts of zero and one add nothing to the sum.
				if (mem_rdata_q > CNT_W'(1)) begin
					log_req.start = 1'b1;
					log_req.x     = mem_rdata_q;
					state_d       = ST_WAITC;
				end else begin
					state_d = idx_last ? ST_CMP : ST_RD;
				end
			end
			ST_WAITC: begin
				if (log_rsp.done) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				state_d = idx_last ? ST_CMP : ST_RD;
			end
			ST_CMP: begin
				if (n_small || acc_q >= ACC_W'(d_q)) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_cnt_q == DIV_CNT_W'(ENT_W - 1)) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Configuration and run counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spr_q           <= SPR_RESET;
			samples_taken_q <= '0;
			in_range_q      <= '0;
			run_end_q       <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				spr_q <= cfg_wr_data;
			end
			if (in_accept) begin
				run_end_q <= run_end;
				if (run_end) begin
					samples_taken_q <= '0;
					in_range_q      <= '0;
				end else begin
					samples_taken_q <= taken[CNT_W-1:0];
					in_range_q      <= n_new;
				end
			end
		end
	end

	// Bin walk index, shared by the clearing pass after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					idx_q <= idx_last ? '0 : idx_q + BIN_W'(1);
				end
				ST_EVAL: begin
					idx_q <= '0;
				end
				ST_CHK: begin
					if (mem_rdata_q <= CNT_W'(1) && !idx_last) begin
						idx_q <= idx_q + BIN_W'(1);
					end
				end
				ST_ACC: begin
					if (!idx_last) begin
						idx_q <= idx_q + BIN_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (state_q == ST_CMP) begin
			div_cnt_q <= '0;
		end else if (state_q == ST_DIV) begin
			div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
		end
	end

	// Datapath: sample address, products, the sum and the divider.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			addr_q <= sample_bin[BIN_W-1:0];
			if (run_end) begin
				n_q <= n_new;
			end
		end
		case (state_q)
			ST_EVAL: begin
				acc_q <= '0;
			end
			ST_WAITN: begin
				if (log_rsp.done) begin
					d_q <= D_W'(n_q) * D_W'(log_rsp.result);
				end
			end
			ST_CHK: begin
				c_q <= mem_rdata_q;
			end
			ST_WAITC: begin
				if (log_rsp.done) begin
					prod_q <= D_W'(c_q) * D_W'(log_rsp.result);
				end
			end
			ST_ACC: begin
				acc_q <= acc_q + ACC_W'(prod_q);
			end
			ST_CMP: begin
				rem_q  <= {1'b0, d_q - acc_q[D_W-1:0]};
				quot_q <= '0;
			end
			ST_DIV: begin
				rem_q  <= rem_ge ? rem_shift - {1'b0, d_q} : rem_shift;
				quot_q <= {quot_q[ENT_W-2:0], rem_ge};
			end
			default: begin
			end
		endcase
	end

	hee_log2 u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (log_req),
		.rsp    (log_rsp)
	);

	// Output register. The quotient never exceeds 1.0, so it always fits
	// the 17-bit field without clipping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			entropy_q <= quot_q;
			degen_q   <= n_small;
			counted_q <= n_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign entropy_q16     = entropy_q;
	assign degenerate      = degen_q;
	assign counted_samples = counted_q;

	`HEE_ASSERT(a_log_no_restart, log_req.start |-> !log_rsp.busy, "log2 unit restarted while busy")
	`HEE_ASSERT(a_degen_total, out_valid_q |-> (degen_q == (counted_q < CNT_W'(2))), "degenerate flag does not match total")
	`HEE_ASSERT(a_degen_zero, (out_valid_q && degen_q) |-> (entropy_q == '0), "degenerate result with nonzero entropy")
	`HEE_ASSERT(a_entropy_max, out_valid_q |-> (entropy_q <= ENT_W'(17'h10000)), "entropy above one")
	`HEE_ASSERT_NEXT(a_inc_follows, in_accept && in_range, state_q == ST_INC, "in-range beat not written back")

endmodule

/* verif/tb_histogram_entropy_estimator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_histogram_entropy_estimator_core
// Drives sample beats into the entropy estimator and checks each run result
// against a cycle-free software predictor of the histogram and fixed-point
// entropy math, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_histogram_entropy_estimator_core;
	import hee_pkg::*;

	localparam int NUM_BINS = 64;

	// The end of a run walks every bin, and a busy bin needs a full log2
	// evaluation, so the worst case is all bins busy plus the divider.
	localparam int RUN_END_CYCLES = 2 * NUM_BINS + 18 * NUM_BINS + 40;
	// Quiet time before a register write and at the end of the test.
	localparam int DRAIN_CYCLES = RUN_END_CYCLES + 100;
	// Cycles without any beat on either channel before the test gives up.
	localparam int STALL_LIMIT = 8 * DRAIN_CYCLES;
	localparam int ITEMS_PER_HALF = 84;
	localparam logic [ENT_W-1:0] ENT_MAX = '1;

	typedef struct packed {
		logic [ENT_W-1:0] entropy;
		logic             degen;
		logic [CNT_W-1:0] count;
	} run_result_t;

	// Tracks the histogram the block should hold, works out the entropy of
	// each finished run, and compares the block's results in order.
	class entropy_scoreboard;
		logic [CNT_W-1:0] bin_hist [NUM_BINS];
		logic [CNT_W-1:0] taken;
		logic [CNT_W-1:0] in_range;
		logic [CNT_W-1:0] run_len;
		run_result_t      expected_runs [$];
		int               fail_count;

		function new();
			foreach (bin_hist[i])
				bin_hist[i] = '0;
			taken = '0;
			in_range = '0;
			run_len = SPR_RESET;
			fail_count = 0;
		endfunction

		// log2 in Q4.16 by repeated squaring of a Q1.30 mantissa.
		function logic [LOG_W-1:0] log2_q16(logic [CNT_W-1:0] x);
			logic [E_W-1:0]    e;
			logic [FRAC_W-1:0] frac;
			logic [63:0]       y;
			e = '0;
			frac = '0;
			if (x == 0)
				return '0;
			for (int k = 0; k < CNT_W; k++)
				if (x[k])
					e = E_W'(k);
			y = 64'(x) << (30 - e);
			for (int k = 0; k < FRAC_W; k++) begin
				y = (y * y) >> 30;
				frac = {frac[FRAC_W-2:0], 1'b0};
				if (y >= 64'h8000_0000) begin
					y = y >> 1;
					frac[0] = 1'b1;
				end
			end
			return {e, frac};
		endfunction

		function void note_sample(logic [SAMPLE_W-1:0] bin);
			logic [31:0] limit;
			logic [31:0] next_taken;
			logic [63:0] d;
			logic [63:0] s;
			logic [63:0] q;
			run_result_t r;
			// A run length of zero behaves as one.
			limit = (run_len == 0) ? 32'd1 : 32'(run_len);
			if (bin < NUM_BINS) begin
				bin_hist[bin] = bin_hist[bin] + 1'b1;
				in_range = in_range + 1'b1;
			end
			next_taken = 32'(taken) + 1;
			if (next_taken < limit) begin
				taken = CNT_W'(next_taken);
				return;
			end
			r = '0;
			r.count = in_range;
			if (in_range < 2) begin
				r.degen = 1'b1;
			end else begin
				d = 64'(in_range) * 64'(log2_q16(in_range));
				s = '0;
				foreach (bin_hist[i])
					s += 64'(bin_hist[i]) * 64'(log2_q16(bin_hist[i]));
				// Rounding can push S up to D; the entropy then stays zero.
				if (s < d) begin
					q = ((d - s) << 16) / d;
					r.entropy = (q > 64'(ENT_MAX)) ? ENT_MAX : q[ENT_W-1:0];
				end
			end
			expected_runs.push_back(r);
			foreach (bin_hist[i])
				bin_hist[i] = '0;
			taken = '0;
			in_range = '0;
		endfunction

		task report(string msg);
			$display("%0t ns  MISMATCH  %s", $time, msg);
			fail_count++;
		endtask

		task check_result(logic [ENT_W-1:0] ent, logic degen, logic [CNT_W-1:0] cnt);
			run_result_t want;
			if (expected_runs.size() == 0) begin
				report($sformatf("unexpected result entropy=%0d degenerate=%0d count=%0d",
					ent, degen, cnt));
				return;
			end
			want = expected_runs.pop_front();
			if (ent !== want.entropy)
				report($sformatf("entropy_q16 got %0d want %0d", ent, want.entropy));
			if (degen !== want.degen)
				report($sformatf("degenerate got %0d want %0d", degen, want.degen));
			if (cnt !== want.count)
				report($sformatf("counted_samples got %0d want %0d", cnt, want.count));
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [CNT_W-1:0]    cfg_wr_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [SAMPLE_W-1:0] sample_bin = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [ENT_W-1:0]    entropy_q16;
	logic                degenerate;
	logic [CNT_W-1:0]    counted_samples;

	entropy_scoreboard sb;
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int stall_cycles = 0;

	histogram_entropy_estimator_core #(
		.NUM_BINS(NUM_BINS)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample_bin     (sample_bin),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.entropy_q16    (entropy_q16),
		.degenerate     (degenerate),
		.counted_samples(counted_samples)
	);

	always #5 clk = ~clk;

	// The receiver decides each cycle, at the falling edge, whether it will
	// take a result beat; this stalls the output register at random points
	// of the run walk, independent of whether a result is waiting.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
	end

	// Both channels are sampled at the rising edge, where everything the
	// testbench drives has been stable since the falling edge. An accepted sample
	// beat updates the predicted histogram at once, so the expectation for
	// a run exists before its result can possibly show up.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_sample(sample_bin);
			if (out_valid && out_ready)
				sb.check_result(entropy_q16, degenerate, counted_samples);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
	end

	// Watchdog: the longest legitimate quiet stretch is a run walk or one of
	// the drain pauses, both far below the limit.
	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(negedge clk);
		$display("%0t ns  no beat for %0d cycles, giving up", $time, STALL_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	// Offers one sample beat. The sender may first idle for a random number
	// of cycles with valid low; once valid is raised it holds, with the same
	// bin, until the block takes it. Valid is left high on return so that
	// back-to-back beats need no low cycle in between.
	task automatic send_sample(input logic [SAMPLE_W-1:0] bin);
		@(negedge clk);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample_bin <= bin;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Stops the sample stream, waits for every predicted result, and then
	// gives a run walk that might still be in progress time to finish, so
	// that a register write cannot land in the middle of a run.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.expected_runs.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_run_length(input logic [CNT_W-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.run_len = value;
	endtask

	// Mostly in-range bins; a share piles into a few bins to get low
	// entropies and busy bins, and a share spans the full field so that
	// out-of-range values and every bit of the index show up.
	function automatic logic [SAMPLE_W-1:0] pick_bin();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return SAMPLE_W'($urandom_range(0, 255));
		else if (r < 50)
			return SAMPLE_W'($urandom_range(0, 3));
		return SAMPLE_W'($urandom_range(0, NUM_BINS - 1));
	endfunction

	initial begin
		logic [SAMPLE_W-1:0] mixed_bins [12];
		sb = new();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, with light idling on both sides.
		snd_idle_pct = 30;
		rcv_idle_pct = 30;

		// A run length of zero acts as one: each beat closes a run. One
		// in-range sample and one far out of range give both degenerate
		// cases, a single counted sample and none.
		write_run_length('0);
		send_sample(8'd0);
		send_sample(8'd255);
		settle();

		// Runs of four: all in the top bin (zero entropy, where rounding
		// meets S = D), four distinct bins (full entropy), and a run with
		// two out-of-range beats leaving a pair in one bin.
		write_run_length(16'd4);
		mixed_bins = '{8'd63, 8'd63, 8'd63, 8'd63,
			8'd0, 8'd1, 8'd2, 8'd3,
			8'd64, 8'd128, 8'd5, 8'd5};
		foreach (mixed_bins[i])
			send_sample(mixed_bins[i]);
		settle();

		// Longest run length, then lowered to two after three beats: the
		// next beat must close the run at once.
		write_run_length(16'hFFFF);
		send_sample(8'd10);
		send_sample(8'd20);
		send_sample(8'd30);
		settle();
		write_run_length(16'd2);
		send_sample(8'd40);
		settle();

		// Run length one with a single in-range and the first out-of-range bin.
		write_run_length(16'd1);
		send_sample(8'd7);
		send_sample(8'd64);
		settle();

		// Random part in three idling phases, each split in two halves with
		// their own run length. The very last half uses long runs.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					snd_idle_pct = 15;
					rcv_idle_pct = 83;
				end
				1: begin
					snd_idle_pct = 83;
					rcv_idle_pct = 15;
				end
				default: begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			for (int half = 0; half < 2; half++) begin
				if (phase == 2 && half == 1)
					write_run_length(CNT_W'($urandom_range(40, 90)));
				else
					write_run_length(CNT_W'($urandom_range(1, 12)));
				repeat (ITEMS_PER_HALF) send_sample(pick_bin());
				settle();
			end
		end

		if (sb.fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* sim.f */
+incdir+sv
sv/hee_pkg.sv
sv/hee_log2.sv
sv/histogram_entropy_estimator_core.sv
verif/tb_histogram_entropy_estimator_core.sv
